### rtl/gwc_pkg.sv
// gwc_pkg: shared constants, types and helper functions for the gray window
// convolver. No dependencies; imported by every module under rtl/ except gwc_ram.
package gwc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_KERNEL = 7;
  localparam int LINES      = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int HALF_MAX   = (MAX_KERNEL - 1) / 2;
  localparam int TAPS       = MAX_KERNEL * MAX_KERNEL;

  localparam int PIX_W  = 8;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 16;
  localparam int WID_W  = 11;
  localparam int HALF_W = 2;
  localparam int IDX_W  = 6;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int PROD_W = 2 * PIX_W;
  localparam int RSUM_W = PROD_W + $clog2(MAX_KERNEL);
  localparam int TSUM_W = RSUM_W + $clog2(MAX_KERNEL);

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [WID_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0]  HEIGHT_RST = 16'd480;
  localparam logic [HALF_W-1:0] HALF_RST   = 2'd1;

  typedef enum logic {
    OP_COEF  = 1'b0,
    OP_PIXEL = 1'b1
  } gwc_op_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_HALF   = 2'd2
  } gwc_cfg_idx_t;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [PROD_W-1:0] prod_t;

  // effective (clamped) frame geometry
  typedef struct packed {
    logic [WID_W-1:0]  width;
    logic [ROW_W-1:0]  height;
    logic [HALF_W-1:0] half;
  } gwc_cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } gwc_meta_t;

  function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] raw);
    logic [WID_W-1:0] w;
    w = raw;
    if (raw == '0) w = WID_W'(1);
    else if (raw > WID_W'(MAX_WIDTH)) w = WID_W'(MAX_WIDTH);
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] raw);
    return (raw == '0) ? ROW_W'(1) : raw;
  endfunction

  function automatic logic [HALF_W-1:0] eff_half(input logic [HALF_W-1:0] raw);
    return ({1'b0, raw} > (HALF_W+1)'(HALF_MAX)) ? HALF_W'(HALF_MAX) : raw;
  endfunction

endpackage

### rtl/gwc_ram.sv
// gwc_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module gwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/gwc_front.sv
// gwc_front: raster counters, input stage, line store, window and kernel
// registers, and the registered product array. Uses gwc_pkg and gwc_ram.
module gwc_front (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  gwc_pkg::gwc_cfg_t                          cfg,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic                                       in_op,
  input  logic [gwc_pkg::IDX_W-1:0]                  in_coef_index,
  input  logic [gwc_pkg::PIX_W-1:0]                  in_coef_value,
  input  logic [gwc_pkg::PIX_W-1:0]                  in_pixel,
  output logic                                       b_valid,
  input  logic                                       b_ready,
  output gwc_pkg::prod_t [gwc_pkg::TAPS-1:0]         b_prod,
  output gwc_pkg::gwc_meta_t                         b_meta
);
  import gwc_pkg::*;

  logic             accept;
  logic             a_go;
  logic             a_pix;
  logic             b_free;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WID_W-1:0] col_inc;
  logic [ROW_W:0]   row_inc;
  logic [HALF_W:0]  h2;
  logic             emit;
  logic             interior;
  gwc_meta_t        meta;

  logic             a_valid_r;
  logic             a_op_r;
  logic [IDX_W-1:0] a_idx_r;
  pix_t             a_cv_r;
  pix_t             a_pix_r;
  logic [ADDR_W-1:0] a_addr_r;
  logic             a_emit_r;
  logic             a_int_r;
  gwc_meta_t        a_meta_r;

  logic                         ram_we;
  logic [LINES-1:0][PIX_W-1:0]  ram_q;
  logic [LINES-1:0][PIX_W-1:0]  ram_wd;
  logic [LINES-1:0][PIX_W-1:0]  lines;
  logic [LINES-1:0][PIX_W-1:0]  fwd_data_r;
  logic                         fwd_hit_r;

  pix_t [MAX_KERNEL-1:0]                  colvec;
  pix_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0]  win_r, win_nxt;
  pix_t [TAPS-1:0]                        kern_r;
  prod_t [TAPS-1:0]                       prod;

  logic             b_valid_r;
  prod_t [TAPS-1:0] b_prod_r;
  gwc_meta_t        b_meta_r;

  // raster position of the incoming pixel
  assign col_inc = {1'b0, col_r} + WID_W'(1);
  assign row_inc = {1'b0, row_r} + (ROW_W+1)'(1);
  assign h2      = {cfg.half, 1'b0};

  always_comb begin
    col_nxt = col_inc[COL_W-1:0];
    row_nxt = row_r;
    if (col_inc >= cfg.width) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, cfg.height}) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  assign emit     = (row_r >= ROW_W'(cfg.half)) && (col_r >= COL_W'(cfg.half));
  assign interior = (row_r >= ROW_W'(h2)) && (col_r >= COL_W'(h2)) &&
                    (row_r < cfg.height) && ({1'b0, col_r} < cfg.width);
  assign meta.row  = row_r - ROW_W'(cfg.half);
  assign meta.col  = col_r - COL_W'(cfg.half);
  assign meta.last = (row_inc == {1'b0, cfg.height}) && (col_inc == cfg.width);

  // input stage handshake
  assign a_pix    = (a_op_r == OP_PIXEL);
  assign b_free   = !b_valid_r || b_ready;
  assign a_go     = a_valid_r && (!a_pix || !a_emit_r || b_free);
  assign in_stall = a_valid_r && !a_go;
  assign accept   = in_valid && !in_stall;

  // line store: one word per column holds all buffered rows
  assign ram_we = a_go && a_pix;

  gwc_ram #(
    .WIDTH (LINES * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_addr_r),
    .wdata (ram_wd),
    .re    (accept),
    .raddr (col_r[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  assign lines = fwd_hit_r ? fwd_data_r : ram_q;

  always_comb begin
    ram_wd[0] = a_pix_r;
    for (int j = 1; j < LINES; j++) begin
      ram_wd[j] = lines[j-1];
    end
    colvec[0] = a_pix_r;
    for (int j = 1; j < MAX_KERNEL; j++) begin
      colvec[j] = lines[j-1];
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_KERNEL; j++) begin
      for (int i = 0; i < MAX_KERNEL - 1; i++) begin
        win_nxt[j][i] = win_r[j][i+1];
      end
      win_nxt[j][MAX_KERNEL-1] = colvec[j];
    end
  end

  // tap (ky,kx) pairs with window row 2h-ky, column K-1-2h+kx
  always_comb begin
    pix_t sel;
    logic tap_on;
    for (int ky = 0; ky < MAX_KERNEL; ky++) begin
      for (int kx = 0; kx < MAX_KERNEL; kx++) begin
        sel    = '0;
        tap_on = 1'b0;
        for (int hh = 0; hh <= HALF_MAX; hh++) begin
          if (cfg.half == HALF_W'(hh) && ky <= 2 * hh && kx <= 2 * hh) begin
            sel    = win_nxt[2*hh-ky][MAX_KERNEL-1-2*hh+kx];
            tap_on = 1'b1;
          end
        end
        prod[ky*MAX_KERNEL+kx] = (a_int_r && tap_on) ?
            PROD_W'(sel) * PROD_W'(kern_r[ky*MAX_KERNEL+kx]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      fwd_hit_r <= 1'b0;
      win_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
        fwd_hit_r <= ram_we && (a_addr_r == col_r[ADDR_W-1:0]);
      end else if (a_go) begin
        a_valid_r <= 1'b0;
      end
      if (accept && in_op == OP_PIXEL) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (a_go && a_pix) begin
        win_r <= win_nxt;
      end
      if (a_go && a_pix && a_emit_r) begin
        b_valid_r <= 1'b1;
      end else if (b_ready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op_r     <= in_op;
      a_idx_r    <= in_coef_index;
      a_cv_r     <= in_coef_value;
      a_pix_r    <= in_pixel;
      a_addr_r   <= col_r[ADDR_W-1:0];
      a_emit_r   <= emit;
      a_int_r    <= interior;
      a_meta_r   <= meta;
      fwd_data_r <= ram_wd;
    end
    if (a_go && !a_pix && a_idx_r < IDX_W'(TAPS)) begin
      kern_r[a_idx_r] <= a_cv_r;
    end
    if (a_go && a_pix && a_emit_r) begin
      b_prod_r <= prod;
      b_meta_r <= a_meta_r;
    end
  end

  assign b_valid = b_valid_r;
  assign b_prod  = b_prod_r;
  assign b_meta  = b_meta_r;

endmodule

### rtl/gwc_sum.sv
// gwc_sum: two-level registered adder tree over the product array, then
// saturation into the result register. Uses gwc_pkg.
module gwc_sum (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 b_valid,
  output logic                                 b_ready,
  input  gwc_pkg::prod_t [gwc_pkg::TAPS-1:0]   b_prod,
  input  gwc_pkg::gwc_meta_t                   b_meta,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [gwc_pkg::ROW_W-1:0]            out_row,
  output logic [gwc_pkg::COL_W-1:0]            out_col,
  output logic [gwc_pkg::PIX_W-1:0]            out_value,
  output logic                                 out_frame_last
);
  import gwc_pkg::*;

  logic                              out_ready;
  logic                              c_valid_r;
  logic [MAX_KERNEL-1:0][RSUM_W-1:0] row_sum;
  logic [MAX_KERNEL-1:0][RSUM_W-1:0] c_rows_r;
  gwc_meta_t                         c_meta_r;
  logic [TSUM_W-1:0]                 tsum;
  pix_t                              sat;
  logic                              out_valid_r;
  gwc_meta_t                         out_meta_r;
  pix_t                              out_value_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign b_ready   = !c_valid_r || out_ready;

  always_comb begin
    for (int ky = 0; ky < MAX_KERNEL; ky++) begin
      row_sum[ky] = '0;
      for (int kx = 0; kx < MAX_KERNEL; kx++) begin
        row_sum[ky] = row_sum[ky] + RSUM_W'(b_prod[ky*MAX_KERNEL+kx]);
      end
    end
  end

  always_comb begin
    tsum = '0;
    for (int ky = 0; ky < MAX_KERNEL; ky++) begin
      tsum = tsum + TSUM_W'(c_rows_r[ky]);
    end
    sat = (tsum > TSUM_W'(PIX_MAX)) ? PIX_MAX : tsum[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_valid && b_ready) begin
        c_valid_r <= 1'b1;
      end else if (out_ready) begin
        c_valid_r <= 1'b0;
      end
      if (c_valid_r && out_ready) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_ready) begin
      c_rows_r <= row_sum;
      c_meta_r <= b_meta;
    end
    if (c_valid_r && out_ready) begin
      out_meta_r  <= c_meta_r;
      out_value_r <= sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_meta_r.row;
  assign out_col        = out_meta_r.col;
  assign out_value      = out_value_r;
  assign out_frame_last = out_meta_r.last;

endmodule

### rtl/gray_window_convolve_clamp.sv
// gray_window_convolve_clamp: top level, configuration registers and checks.
// Uses gwc_pkg, gwc_front (with gwc_ram) and gwc_sum.
//
//   channel  direction  handshake           word
//   in_      in         in_valid/in_stall   op, coef_index, coef_value, pixel
//   out_     out        out_valid/out_stall row, col, value, frame_last
//   cfg_     in         cfg_valid/cfg_ready index, data (always ready)
//
// One word per clock in steady state while out_stall is low.
// The line store RAM is read once at acceptance and written once as the pixel
// leaves the input stage; same-column back-to-back pixels are forwarded.
// Reset clears counters, window and pipeline valids; kernel and line store are
// undefined until written. out_stall backs up through the product and sum
// stages before in_stall rises.
module gray_window_convolve_clamp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [gwc_pkg::IDX_W-1:0]    in_coef_index,
  input  logic [gwc_pkg::PIX_W-1:0]    in_coef_value,
  input  logic [gwc_pkg::PIX_W-1:0]    in_pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gwc_pkg::ROW_W-1:0]    out_row,
  output logic [gwc_pkg::COL_W-1:0]    out_col,
  output logic [gwc_pkg::PIX_W-1:0]    out_value,
  output logic                         out_frame_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gwc_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [gwc_pkg::CFG_DW-1:0]   cfg_data
);
  import gwc_pkg::*;

  logic [WID_W-1:0]  width_r;
  logic [ROW_W-1:0]  height_r;
  logic [HALF_W-1:0] half_r;
  gwc_cfg_t          cfg;

  logic              b_valid;
  logic              b_ready;
  prod_t [TAPS-1:0]  b_prod;
  gwc_meta_t         b_meta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      half_r   <= HALF_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gwc_cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
        CFG_HALF:   half_r   <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.width  = eff_width(width_r);
  assign cfg.height = eff_height(height_r);
  assign cfg.half   = eff_half(half_r);

  gwc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_pixel      (in_pixel),
    .b_valid       (b_valid),
    .b_ready       (b_ready),
    .b_prod        (b_prod),
    .b_meta        (b_meta)
  );

  gwc_sum u_sum (
    .clk            (clk),
    .rst_n          (rst_n),
    .b_valid        (b_valid),
    .b_ready        (b_ready),
    .b_prod         (b_prod),
    .b_meta         (b_meta),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_frame_last (out_frame_last)
  );

`ifndef SYNTH
  // input back-pressure only once every stage down to the result is full
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall raised while result stage can move");

  // pipeline comes out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");
`endif

endmodule
